>>> rtl/cccc_pkg.sv
// Shared types and constants for the complementary color clash check.
// Holds the channel words, the divider lane and stage records, and the register map.
// Depends on nothing; every module of the block imports it.
package cccc_pkg;

    // Hue scale: 1/64 degree, full turn, half turn and one sixth of a turn
    localparam logic [14:0] HUE_FULL  = 15'd23040;
    localparam logic [14:0] HUE_HALF  = 15'd11520;
    localparam logic [11:0] HUE_SIXTH = 12'd3840;

    // Saturation is Q1.10
    localparam int SAT_FRAC_BITS = 10;

    // One divider cell per quotient bit
    localparam int N_STEPS = 15;

    // Lanes carried through the divider chain
    localparam int N_LANES      = 4;
    localparam int LANE_TOP_HUE = 0;
    localparam int LANE_TOP_SAT = 1;
    localparam int LANE_BOT_HUE = 2;
    localparam int LANE_BOT_SAT = 3;

    // Configuration register map
    typedef enum logic [1:0] {
        CFG_SAT_NUM   = 2'd0,
        CFG_SAT_DEN   = 2'd1,
        CFG_BAND_LOW  = 2'd2,
        CFG_BAND_HIGH = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 14;

    typedef struct packed {
        logic [7:0] top_red;
        logic [7:0] top_green;
        logic [7:0] top_blue;
        logic [7:0] bottom_red;
        logic [7:0] bottom_green;
        logic [7:0] bottom_blue;
        logic       mode_is_normal;
    } t_in_word;

    typedef struct packed {
        logic [14:0] top_hue;
        logic [10:0] top_sat;
        logic [14:0] bottom_hue;
        logic [10:0] bottom_sat;
        logic [13:0] hue_distance;
        logic        clash;
    } t_out_word;

    // Restoring divider lane: partial remainder, divisor, and the working
    // word that feeds dividend bits out the top and takes quotient bits in
    typedef struct packed {
        logic [7:0]  rem;
        logic [7:0]  den;
        logic [14:0] w;
    } t_lane;

    typedef struct packed {
        logic                      valid;
        logic                      mode;
        t_lane [N_LANES-1:0]       lane;
    } t_stage;

    typedef struct packed {
        logic [7:0]  sat_num;
        logic [7:0]  sat_den;
        logic [13:0] band_low;
        logic [13:0] band_high;
    } t_cfg;

endpackage

>>> rtl/complementary_color_clash_check_top.sv
// Top level of the complementary color clash check.
// Instantiates cccc_prep, a chain of cccc_cell dividers and cccc_finish; holds the registers.
// Depends on cccc_pkg.
//
//   channel   handshake             payload      width
//   -------   -------------------   ----------   -----
//   input     i_start & !o_busy     i_in         49
//   result    o_done (one cycle)    o_result     67
//   config    i_cfg_we              i_cfg_idx    2 + 14 (i_cfg_data)
//
// One word is taken every cycle; o_busy stays low.
// The pipeline has one setup stage, 15 divider cells (one quotient bit
// each, all four lanes in parallel) and one result stage.
// Reset is synchronous; it clears the stage valid bits and loads the register defaults.
// The receiver cannot stall: each result shows for exactly one cycle.
module complementary_color_clash_check_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  cccc_pkg::t_in_word        i_in,
    output logic                      o_done,
    output cccc_pkg::t_out_word       o_result,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [cccc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cccc_pkg::*;

    t_cfg   r_cfg;
    t_stage w_stage [0:N_STEPS];

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sat_num   <= 8'd7;
            r_cfg.sat_den   <= 8'd10;
            r_cfg.band_low  <= 14'd8640;
            r_cfg.band_high <= 14'd11520;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAT_NUM:   r_cfg.sat_num   <= i_cfg_data[7:0];
                CFG_SAT_DEN:   r_cfg.sat_den   <= i_cfg_data[7:0];
                CFG_BAND_LOW:  r_cfg.band_low  <= i_cfg_data;
                CFG_BAND_HIGH: r_cfg.band_high <= i_cfg_data;
                default:       r_cfg.sat_num   <= r_cfg.sat_num;
            endcase
        end
    end

    assign o_busy = 1'b0;

    cccc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_stage (w_stage[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar g = 0; g < N_STEPS; g++) begin : g_cell
        cccc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    cccc_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_stage[N_STEPS]),
        .i_cfg    (r_cfg),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##17 o_done)
        else $error("result strobe missing after fixed latency");

    // A clash needs nonzero saturation on both colors
    a_clash_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.clash) |-> (o_result.top_sat != 11'd0
                                        && o_result.bottom_sat != 11'd0))
        else $error("clash raised with zero saturation");

    // Distance stays on the short way round
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.hue_distance <= 14'(HUE_HALF)))
        else $error("hue distance beyond half turn");

    // Saturation never exceeds one
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.top_sat <= 11'd1024 && o_result.bottom_sat <= 11'd1024))
        else $error("saturation beyond one");

endmodule

>>> rtl/cccc_prep.sv
// Front stage: max/min/delta of both colors and the divider lane setup.
// Produces the hue and saturation dividends and divisors for the cell chain.
// Depends on cccc_pkg.
module cccc_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cccc_pkg::t_in_word i_in,
    output cccc_pkg::t_stage   o_stage
);
    import cccc_pkg::*;

    t_stage r_stage;
    t_stage n_stage;

    // Build the hue lane: dividend 3840*k over delta, k = m*delta + x - y
    function automatic t_lane hue_lane(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  delta;
        logic [2:0]  m;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [10:0] k;
        logic [22:0] num;
        t_lane       l;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        // red wins a tie for the maximum, then green
        priority if (mx == r) begin
            m = (g >= b) ? 3'd0 : 3'd6;
            x = g;
            y = b;
        end else if (mx == g) begin
            m = 3'd2;
            x = b;
            y = r;
        end else begin
            m = 3'd4;
            x = r;
            y = g;
        end
        // modulo arithmetic: the true value is never negative
        k = 11'(delta) * 11'(m) + 11'(x) - 11'(y);
        num = 23'(k) * 23'(HUE_SIXTH);
        l.rem = num[22:15];
        l.den = delta;
        l.w   = num[14:0];
        return l;
    endfunction

    // Build the saturation lane: dividend delta << 10 over max
    function automatic t_lane sat_lane(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [22:0] num;
        t_lane       l;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        num = 23'(mx - mn) << SAT_FRAC_BITS;
        l.rem = num[22:15];
        l.den = mx;
        l.w   = num[14:0];
        return l;
    endfunction

    // Set up all four lanes from the incoming word
    always_comb begin
        n_stage.valid = i_start;
        n_stage.mode  = i_in.mode_is_normal;
        n_stage.lane[LANE_TOP_HUE] = hue_lane(i_in.top_red, i_in.top_green, i_in.top_blue);
        n_stage.lane[LANE_TOP_SAT] = sat_lane(i_in.top_red, i_in.top_green, i_in.top_blue);
        n_stage.lane[LANE_BOT_HUE] = hue_lane(i_in.bottom_red, i_in.bottom_green,
                                              i_in.bottom_blue);
        n_stage.lane[LANE_BOT_SAT] = sat_lane(i_in.bottom_red, i_in.bottom_green,
                                              i_in.bottom_blue);
    end

    // Register the stage; only valid is control
    always_ff @(posedge i_clk) begin
        r_stage.mode <= n_stage.mode;
        r_stage.lane <= n_stage.lane;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/cccc_cell.sv
// One divider cell: takes one restoring division step on each of the four lanes.
// Cells are chained; each hands its registered stage to the next every cycle.
// Depends on cccc_pkg.
module cccc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cccc_pkg::t_stage i_stage,
    output cccc_pkg::t_stage o_stage
);
    import cccc_pkg::*;

    t_stage r_stage;
    t_stage n_stage;

    // Shift in the next dividend bit, subtract the divisor if it fits
    function automatic t_lane div_step(input t_lane l);
        logic [8:0] t;
        t_lane      o;
        t = {l.rem, l.w[14]};
        o = l;
        if (t >= {1'b0, l.den}) begin
            o.rem = 8'(t - {1'b0, l.den});
            o.w   = {l.w[13:0], 1'b1};
        end else begin
            o.rem = t[7:0];
            o.w   = {l.w[13:0], 1'b0};
        end
        return o;
    endfunction

    // Step every lane, pass the sideband along
    always_comb begin
        n_stage       = i_stage;
        for (int i = 0; i < N_LANES; i++) begin
            n_stage.lane[i] = div_step(i_stage.lane[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.mode <= n_stage.mode;
        r_stage.lane <= n_stage.lane;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/cccc_finish.sv
// Back stage: special cases, circular hue distance, saturation tests and clash.
// Registers the result word and its strobe.
// Depends on cccc_pkg.
module cccc_finish (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cccc_pkg::t_stage   i_stage,
    input  cccc_pkg::t_cfg     i_cfg,
    output logic               o_done,
    output cccc_pkg::t_out_word o_result
);
    import cccc_pkg::*;

    logic      r_done;
    t_out_word r_result;
    t_out_word n_result;

    logic [14:0] h_top;
    logic [14:0] h_bot;
    logic [10:0] s_top;
    logic [10:0] s_bot;
    logic [14:0] diff;
    logic [13:0] hue_dist;
    logic [17:0] sat_limit;
    logic        top_ok;
    logic        bot_ok;

    // Grey gives hue zero, black gives saturation zero
    always_comb begin
        h_top = (i_stage.lane[LANE_TOP_HUE].den == 8'd0) ? 15'd0
                                                          : i_stage.lane[LANE_TOP_HUE].w;
        h_bot = (i_stage.lane[LANE_BOT_HUE].den == 8'd0) ? 15'd0
                                                          : i_stage.lane[LANE_BOT_HUE].w;
        s_top = (i_stage.lane[LANE_TOP_SAT].den == 8'd0) ? 11'd0
                                                          : i_stage.lane[LANE_TOP_SAT].w[10:0];
        s_bot = (i_stage.lane[LANE_BOT_SAT].den == 8'd0) ? 11'd0
                                                          : i_stage.lane[LANE_BOT_SAT].w[10:0];
    end

    // Fold the hue difference onto the short way round
    always_comb begin
        diff = (h_top >= h_bot) ? (h_top - h_bot) : (h_bot - h_top);
        if (diff > HUE_HALF) begin
            hue_dist = 14'(HUE_FULL - diff);
        end else begin
            hue_dist = diff[13:0];
        end
    end

    // Saturation exceeds num/den when s*den > num*1024
    always_comb begin
        sat_limit = {i_cfg.sat_num, 10'd0};
        top_ok    = (19'(s_top) * 19'(i_cfg.sat_den)) > 19'(sat_limit);
        bot_ok    = (19'(s_bot) * 19'(i_cfg.sat_den)) > 19'(sat_limit);
    end

    always_comb begin
        n_result.top_hue      = h_top;
        n_result.top_sat      = s_top;
        n_result.bottom_hue   = h_bot;
        n_result.bottom_sat   = s_bot;
        n_result.hue_distance = hue_dist;
        n_result.clash        = i_stage.mode && top_ok && bot_ok
                                && (hue_dist >= i_cfg.band_low)
                                && (hue_dist <= i_cfg.band_high);
    end

    // Hold the word for one cycle under the strobe
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_stage.valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for complementary_color_clash_check_top.
// Predicts hue, saturation, hue distance and clash for each color pair from a
// shadow copy of the registers; depends on cccc_pkg and the top level only.
`timescale 1ns / 100ps

module testbench;

    import cccc_pkg::*;

    localparam int PIPE_CYCLES = 17;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    t_in_word              i_in = '0;
    logic                  o_done;
    t_out_word             o_result;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow registers, the reports still in flight and the run status
    t_cfg      clash_cfg;
    t_out_word clash_reports_due[$];
    int        err_count = 0;
    int        gap_pct = 0;

    complementary_color_clash_check_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Hue in 1/64 degree and Q1.10 saturation of one RGB color
    function automatic void color_to_hue_sat(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b,
                                             output int unsigned hue,
                                             output int unsigned sat);
        int unsigned rr, gg, bb, mx, mn, dl, num, sixth, full;
        rr = r;
        gg = g;
        bb = b;
        sixth = HUE_SIXTH;
        full = HUE_FULL;
        mx = rr;
        mn = rr;
        if (gg > mx) mx = gg;
        if (bb > mx) mx = bb;
        if (gg < mn) mn = gg;
        if (bb < mn) mn = bb;
        dl = mx - mn;
        sat = (mx == 0) ? 0 : ((dl << SAT_FRAC_BITS) / mx);
        if (dl == 0) begin
            hue = 0;
        end else begin
            // Red wins a tie for the maximum, then green
            if (mx == rr) begin
                if (gg >= bb) num = sixth * (gg - bb);
                else num = full * dl - sixth * (bb - gg);
            end else if (mx == gg) begin
                num = 2 * sixth * dl + sixth * bb - sixth * rr;
            end else begin
                num = 4 * sixth * dl + sixth * rr - sixth * gg;
            end
            hue = num / dl;
        end
    endfunction

    function automatic bit sat_above_threshold(input int unsigned s);
        int unsigned den, num;
        den = clash_cfg.sat_den;
        num = clash_cfg.sat_num;
        return (s * den) > (num << SAT_FRAC_BITS);
    endfunction

    function automatic t_out_word compute_clash_report(input t_in_word w);
        t_out_word   rep;
        int unsigned h1, s1, h2, s2, hue_dist, lo, hi;
        color_to_hue_sat(w.top_red, w.top_green, w.top_blue, h1, s1);
        color_to_hue_sat(w.bottom_red, w.bottom_green, w.bottom_blue, h2, s2);
        hue_dist = (h1 >= h2) ? h1 - h2 : h2 - h1;
        if (hue_dist > HUE_HALF) hue_dist = HUE_FULL - hue_dist;
        lo = clash_cfg.band_low;
        hi = clash_cfg.band_high;
        rep.top_hue = h1[14:0];
        rep.top_sat = s1[10:0];
        rep.bottom_hue = h2[14:0];
        rep.bottom_sat = s2[10:0];
        rep.hue_distance = hue_dist[13:0];
        rep.clash = w.mode_is_normal && sat_above_threshold(s1) && sat_above_threshold(s2)
                    && hue_dist >= lo && hue_dist <= hi;
        return rep;
    endfunction

    function automatic t_in_word color_pair(input int tr, input int tg, input int tb,
                                            input int br, input int bg, input int bb,
                                            input bit normal);
        t_in_word w;
        w.top_red = tr[7:0];
        w.top_green = tg[7:0];
        w.top_blue = tb[7:0];
        w.bottom_red = br[7:0];
        w.bottom_green = bg[7:0];
        w.bottom_blue = bb[7:0];
        w.mode_is_normal = normal;
        return w;
    endfunction

    // Saturated colors facing a jittered complement in half the draws, plus corners and noise
    function automatic t_in_word random_color_pair();
        t_in_word   w;
        int         sel, strong_ch, weak_ch;
        logic [7:0] ch[3];
        sel = $urandom_range(9);
        w = t_in_word'({$urandom, $urandom});
        if (sel < 5) begin
            strong_ch = $urandom_range(2);
            weak_ch = (strong_ch + 1 + $urandom_range(1)) % 3;
            ch[0] = 8'($urandom);
            ch[1] = 8'($urandom);
            ch[2] = 8'($urandom);
            ch[strong_ch] = 8'($urandom_range(180, 255));
            ch[weak_ch] = 8'($urandom_range(0, 60));
            w.top_red = ch[0];
            w.top_green = ch[1];
            w.top_blue = ch[2];
            w.bottom_red = ~ch[0] ^ 8'($urandom_range(0, 31));
            w.bottom_green = ~ch[1] ^ 8'($urandom_range(0, 31));
            w.bottom_blue = ~ch[2] ^ 8'($urandom_range(0, 31));
        end else if (sel < 7) begin
            w.top_red = 8'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
            w.top_green = 8'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
            w.top_blue = 8'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
            if ($urandom_range(3) == 0) w.bottom_green = w.bottom_red;
            if ($urandom_range(3) == 0) w.bottom_blue = w.bottom_red;
        end
        w.mode_is_normal = ($urandom_range(3) != 0);
        return w;
    endfunction

    // Present one word from a falling edge, hold until accepted, return at a falling edge
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_in <= w;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        clash_reports_due = {clash_reports_due, compute_clash_report(w)};
        @(negedge i_clk);
    endtask

    // Drop start and wait until every report in flight has come back
    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (clash_reports_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SAT_NUM:   clash_cfg.sat_num = data[7:0];
            CFG_SAT_DEN:   clash_cfg.sat_den = data[7:0];
            CFG_BAND_LOW:  clash_cfg.band_low = data;
            CFG_BAND_HIGH: clash_cfg.band_high = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_registers(input int num, input int den, input int lo, input int hi);
        write_register(CFG_SAT_NUM, CFG_DATA_W'(num));
        write_register(CFG_SAT_DEN, CFG_DATA_W'(den));
        write_register(CFG_BAND_LOW, CFG_DATA_W'(lo));
        write_register(CFG_BAND_HIGH, CFG_DATA_W'(hi));
    endtask

    task automatic send_random_words(input int count);
        repeat (count) send_word(random_color_pair());
    endtask

    // Corners of the hue wheel, ties for the maximum, grey, black and the threshold edge
    task automatic test_directed_colors();
        send_word(color_pair(0, 0, 0, 0, 0, 0, 1'b1));
        send_word(color_pair(255, 255, 255, 255, 255, 255, 1'b1));
        send_word(color_pair(255, 0, 0, 0, 255, 255, 1'b1));
        send_word(color_pair(255, 0, 0, 0, 255, 255, 1'b0));
        send_word(color_pair(0, 255, 0, 255, 0, 255, 1'b1));
        send_word(color_pair(0, 0, 255, 255, 255, 0, 1'b1));
        send_word(color_pair(255, 0, 1, 0, 255, 254, 1'b1));
        send_word(color_pair(255, 255, 0, 0, 0, 255, 1'b1));
        send_word(color_pair(0, 255, 255, 255, 0, 0, 1'b1));
        send_word(color_pair(255, 0, 255, 0, 255, 0, 1'b1));
        send_word(color_pair(1, 0, 0, 0, 0, 1, 1'b1));
        send_word(color_pair(128, 128, 128, 0, 0, 0, 1'b1));
        send_word(color_pair(255, 255, 255, 255, 255, 255, 1'b0));
        send_word(color_pair(255, 76, 76, 76, 255, 255, 1'b1));
        send_word(color_pair(255, 77, 77, 77, 255, 255, 1'b1));
        send_word(color_pair(255, 128, 0, 0, 128, 255, 1'b1));
        send_word(color_pair(255, 0, 0, 255, 255, 0, 1'b1));
        send_word(color_pair(254, 1, 127, 1, 254, 128, 1'b1));
        send_word(color_pair(170, 85, 170, 85, 170, 85, 1'b1));
        send_word(color_pair(85, 170, 85, 170, 85, 170, 1'b0));
    endtask

    task automatic test_default_registers();
        send_random_words(200);
    endtask

    task automatic test_threshold_extremes();
        // Any nonzero saturation passes, widest band
        set_registers(0, 255, 0, HUE_HALF);
        send_random_words(100);
        // No saturation can pass
        set_registers(255, 1, 0, HUE_HALF);
        send_random_words(60);
    endtask

    task automatic test_zero_denominator();
        set_registers(0, 0, 0, HUE_HALF);
        send_random_words(120);
    endtask

    task automatic test_inverted_band();
        set_registers(1, 4, 9000, 8999);
        send_random_words(120);
    endtask

    task automatic test_band_beyond_range();
        // Band that holds only the exact half turn
        set_registers(7, 10, HUE_HALF, HUE_HALF);
        send_word(color_pair(255, 0, 0, 0, 255, 255, 1'b1));
        send_word(color_pair(0, 0, 255, 255, 255, 0, 1'b1));
        send_random_words(60);
        set_registers(3, 10, 11000, 16383);
        send_random_words(60);
        set_registers(3, 10, 16383, 16383);
        send_random_words(60);
    endtask

    task automatic test_random_settings();
        int lo, hi;
        repeat (8) begin
            lo = $urandom_range(0, 11520);
            hi = $urandom_range(lo, 11520);
            if ($urandom_range(7) == 0) hi = $urandom_range(11520, 16383);
            set_registers($urandom_range(0, 255), $urandom_range(1, 255), lo, hi);
            send_random_words(55);
        end
    endtask

    // Check each report against the oldest prediction
    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_rep;
        if (i_rst_n && o_done) begin
            if (clash_reports_due.size() == 0) begin
                $error("report with none pending: %p", o_result);
                err_count++;
            end else begin
                exp_rep = clash_reports_due.pop_front();
                check_field("top_hue", exp_rep.top_hue, o_result.top_hue);
                check_field("top_sat", exp_rep.top_sat, o_result.top_sat);
                check_field("bottom_hue", exp_rep.bottom_hue, o_result.bottom_hue);
                check_field("bottom_sat", exp_rep.bottom_sat, o_result.bottom_sat);
                check_field("hue_distance", exp_rep.hue_distance, o_result.hue_distance);
                check_field("clash", exp_rep.clash, o_result.clash);
            end
        end
    end

    initial begin
        clash_cfg.sat_num = 8'd7;
        clash_cfg.sat_den = 8'd10;
        clash_cfg.band_low = 14'd8640;
        clash_cfg.band_high = 14'd11520;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct = 22;
        test_directed_colors();
        test_default_registers();
        test_threshold_extremes();
        gap_pct = 79;
        test_zero_denominator();
        test_inverted_band();
        test_band_beyond_range();
        gap_pct = 0;
        test_random_settings();

        drain_pipeline();
        repeat (PIPE_CYCLES + 5) @(negedge i_clk);
        if (err_count == 0 && clash_reports_due.size() == 0) begin
            $display("[complementary_color_clash_check_top] OK");
        end else begin
            $display("[complementary_color_clash_check_top] ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #4_000_000;
        $display("[complementary_color_clash_check_top] ERROR");
        $finish;
    end

endmodule

>>> complementary_color_clash_check_top.f
rtl/cccc_pkg.sv
rtl/cccc_prep.sv
rtl/cccc_cell.sv
rtl/cccc_finish.sv
rtl/complementary_color_clash_check_top.sv
tb/testbench.sv
